// ----- sv/tie_pkg.sv -----
// ----------------------------------------------------------------------------
// tie_pkg
// Shared constants, codes and beat types of the TLV item extractor.
// ----------------------------------------------------------------------------
package tie_pkg;

    localparam int LEN_BYTES_MAX = 4;
    localparam int LEN_W         = 28;
    localparam int CNT_W         = $clog2(LEN_BYTES_MAX + 1);
    localparam int GROUP_W       = 7;

    localparam int PHASE_W = 3;
    localparam logic [PHASE_W-1:0] PH_TYPE   = 3'd0;
    localparam logic [PHASE_W-1:0] PH_LEN    = 3'd1;
    localparam logic [PHASE_W-1:0] PH_SKIP   = 3'd2;
    localparam logic [PHASE_W-1:0] PH_EMIT   = 3'd3;
    localparam logic [PHASE_W-1:0] PH_IGNORE = 3'd4;

    localparam int KIND_W = 3;
    localparam logic [KIND_W-1:0] K_VALUE    = 3'd0;
    localparam logic [KIND_W-1:0] K_NOTFOUND = 3'd1;
    localparam logic [KIND_W-1:0] K_ENDTYPE  = 3'd2;
    localparam logic [KIND_W-1:0] K_BADLEN   = 3'd3;
    localparam logic [KIND_W-1:0] K_CUT      = 3'd4;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } in_beat_t;

    typedef struct packed {
        logic              valid;
        logic [7:0]        value;
        logic [KIND_W-1:0] kind;
        logic              last;
    } result_t;

endpackage

// ----- sv/tie_in_stage.sv -----
// ----------------------------------------------------------------------------
// tie_in_stage
// Input register: holds one buffer byte until the parser consumes it.
// ----------------------------------------------------------------------------
module tie_in_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,
    input  logic              s_tlast,
    input  logic              advance,
    output logic              beat_valid,
    output tie_pkg::in_beat_t beat
);
    import tie_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_beat_t beat_reg;
    logic     load;

    assign s_tready   = !valid_reg || advance;
    assign load       = s_tready;
    assign valid_next = load ? s_tvalid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load && s_tvalid) begin
            beat_reg <= '{data: s_tdata, last: s_tlast};
        end
    end

    assign beat_valid = valid_reg;
    assign beat       = beat_reg;

endmodule

// ----- sv/tie_parser.sv -----
// ----------------------------------------------------------------------------
// tie_parser
// TLV walk state and the per-byte decision, with the wanted-type register.
// ----------------------------------------------------------------------------
module tie_parser (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [7:0]        cfg_wr_data,
    input  logic              consume,
    input  tie_pkg::in_beat_t beat,
    output tie_pkg::result_t  res
);
    import tie_pkg::*;

    logic [7:0]         wanted_reg;
    logic [PHASE_W-1:0] phase_reg;
    logic [PHASE_W-1:0] phase_next;
    logic [7:0]         type_reg;
    logic [7:0]         type_next;
    logic [LEN_W-1:0]   acc_reg;
    logic [LEN_W-1:0]   acc_next;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   cnt_next;
    logic [LEN_W-1:0]   rem_reg;
    logic [LEN_W-1:0]   rem_next;

    logic [LEN_W-1:0]   acc_shift;
    logic [CNT_W-1:0]   cnt_inc;
    logic [LEN_W-1:0]   rem_dec;
    logic               last;

    assign last      = beat.last;
    assign acc_shift = {acc_reg[LEN_W-GROUP_W-1:0], beat.data[GROUP_W-1:0]};
    assign cnt_inc   = cnt_reg + CNT_W'(1);
    assign rem_dec   = rem_reg - LEN_W'(1);

    always_comb begin
        phase_next = phase_reg;
        type_next  = type_reg;
        acc_next   = acc_reg;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        res        = '{valid: 1'b0, value: 8'd0, kind: K_VALUE, last: 1'b0};
        if (consume) begin
            case (phase_reg)
                PH_TYPE: begin
                    type_next = beat.data;
                    if (last) begin
                        res = '{valid: 1'b1, value: 8'd0, kind: K_ENDTYPE, last: 1'b1};
                    end else begin
                        acc_next   = '0;
                        cnt_next   = '0;
                        phase_next = PH_LEN;
                    end
                end
                PH_LEN: begin
                    if (acc_reg[LEN_W-1:LEN_W-GROUP_W] != '0) begin
                        res        = '{valid: 1'b1, value: 8'd0, kind: K_BADLEN, last: 1'b1};
                        phase_next = last ? PH_TYPE : PH_IGNORE;
                    end else begin
                        acc_next = acc_shift;
                        cnt_next = cnt_inc;
                        if (beat.data[7]) begin
                            if (last || cnt_inc >= CNT_W'(LEN_BYTES_MAX)) begin
                                res = '{valid: 1'b1, value: 8'd0, kind: K_BADLEN,
                                        last: 1'b1};
                                phase_next = last ? PH_TYPE : PH_IGNORE;
                            end
                        end else if (acc_shift == '0) begin
                            if (last) begin
                                res = '{valid: 1'b1, value: 8'd0, kind: K_NOTFOUND,
                                        last: 1'b1};
                            end
                            phase_next = PH_TYPE;
                        end else if (last) begin
                            res = '{valid: 1'b1, value: 8'd0, kind: K_CUT, last: 1'b1};
                            phase_next = PH_TYPE;
                        end else begin
                            rem_next   = acc_shift;
                            phase_next = (type_reg == wanted_reg) ? PH_EMIT : PH_SKIP;
                        end
                    end
                end
                PH_SKIP: begin
                    rem_next = rem_dec;
                    if (rem_dec == '0) begin
                        if (last) begin
                            res = '{valid: 1'b1, value: 8'd0, kind: K_NOTFOUND,
                                    last: 1'b1};
                        end
                        phase_next = PH_TYPE;
                    end else if (last) begin
                        res        = '{valid: 1'b1, value: 8'd0, kind: K_CUT, last: 1'b1};
                        phase_next = PH_TYPE;
                    end
                end
                PH_EMIT: begin
                    rem_next = rem_dec;
                    if (rem_dec == '0) begin
                        res = '{valid: 1'b1, value: beat.data, kind: K_VALUE, last: 1'b1};
                        phase_next = last ? PH_TYPE : PH_IGNORE;
                    end else if (last) begin
                        res        = '{valid: 1'b1, value: 8'd0, kind: K_CUT, last: 1'b1};
                        phase_next = PH_TYPE;
                    end else begin
                        res = '{valid: 1'b1, value: beat.data, kind: K_VALUE, last: 1'b0};
                    end
                end
                default: begin
                    if (last) begin
                        phase_next = PH_TYPE;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wanted_reg <= 8'd0;
            phase_reg  <= PH_TYPE;
        end else begin
            if (cfg_wr_en) begin
                wanted_reg <= cfg_wr_data;
            end
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge aclk) begin
        type_reg <= type_next;
        acc_reg  <= acc_next;
        cnt_reg  <= cnt_next;
        rem_reg  <= rem_next;
    end

endmodule

// ----- sv/tie_out_stage.sv -----
// ----------------------------------------------------------------------------
// tie_out_stage
// Result register: holds one result beat until the sink takes it.
// ----------------------------------------------------------------------------
module tie_out_stage (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  tie_pkg::result_t            res,
    output logic                        advance,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [7:0]                  m_tdata,
    output logic [tie_pkg::KIND_W-1:0]  m_tuser,
    output logic                        m_tlast
);
    import tie_pkg::*;

    logic              valid_reg;
    logic              valid_next;
    logic [7:0]        value_reg;
    logic [KIND_W-1:0] kind_reg;
    logic              last_reg;

    assign advance    = !valid_reg || m_tready;
    assign valid_next = advance ? res.valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && res.valid) begin
            value_reg <= res.value;
            kind_reg  <= res.kind;
            last_reg  <= res.last;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = value_reg;
    assign m_tuser  = kind_reg;
    assign m_tlast  = last_reg;

endmodule

// ----- sv/tlv_item_extractor_unit.sv -----
// ----------------------------------------------------------------------------
// tlv_item_extractor_unit
// Walks a TLV buffer with SDNV lengths and forwards the value of the first
// non-empty item of the wanted type, or one status beat per buffer.
//
//   channel   dir  tdata           tuser         tlast
//   s_        in   data_byte[7:0]  -             buffer_last
//   m_        out  value_byte[7:0] result_kind   end_of_result
//   cfg_wr_   in   wanted_type     -             -
//
// One byte per cycle while the result register is not stalled; an input beat
// passes the input register and the decision logic into the result register.
// Synchronous active-low reset clears the phase, wanted_type and both
// valid flags; no clearing pass.
// A stalled result register stalls the parser and then the input register.
// ----------------------------------------------------------------------------
module tlv_item_extractor_unit (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic [7:0]                  cfg_wr_data,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [7:0]                  s_tdata,   // [7:0] data_byte
    input  logic                        s_tlast,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [7:0]                  m_tdata,   // [7:0] value_byte
    output logic [tie_pkg::KIND_W-1:0]  m_tuser,   // [2:0] result_kind
    output logic                        m_tlast
);
    import tie_pkg::*;

    logic     advance;
    logic     beat_valid;
    in_beat_t beat;
    result_t  res;

    tie_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .advance    (advance),
        .beat_valid (beat_valid),
        .beat       (beat)
    );

    tie_parser u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .consume     (beat_valid && advance),
        .beat        (beat),
        .res         (res)
    );

    tie_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .res      (res),
        .advance  (advance),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

`ifndef NO_ASSERTIONS
    a_kind_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser <= K_CUT))
        else $error("result kind out of range");

    a_status_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser != K_VALUE)) |-> (m_tlast && (m_tdata == 8'd0)))
        else $error("status beat not final or carries data");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled while result register empty");
`endif

endmodule

// ----- tb/tlv_item_extractor_unit_test.sv -----
// ----------------------------------------------------------------------------
// tlv_item_extractor_unit_test
// Self-checking bench for the TLV item extractor. Byte buffers go in on the
// s_ stream and a tracking model of the SDNV/TLV walk builds the result
// beats it should produce. Every m_ beat is checked field by field against
// the oldest pending one. Directed buffers cover each status and the
// length-field extremes. A receiver hold-off fills the block up. Random
// buffers, mostly well-formed and some cut, overlong or noise, run under
// three idle profiles and several wanted_type settings.
// ----------------------------------------------------------------------------
module tlv_item_extractor_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import tie_pkg::*;

    localparam int HOLD_CYCLES   = 400;
    localparam int DRAIN_LIMIT   = 50000;
    localparam int SETTLE_CYCLES = 8;

    typedef struct packed {
        logic [7:0]        value;
        logic [KIND_W-1:0] kind;
        logic              eor;
    } tlv_result_t;

    logic              aclk        = 1'b0;
    logic              aresetn     = 1'b0;
    logic              cfg_wr_en   = 1'b0;
    logic [7:0]        cfg_wr_data = '0;
    logic              s_tvalid    = 1'b0;
    logic              s_tready;
    logic [7:0]        s_tdata     = '0;
    logic              s_tlast     = 1'b0;
    logic              m_tvalid;
    logic              m_tready    = 1'b0;
    logic [7:0]        m_tdata;
    logic [KIND_W-1:0] m_tuser;
    logic              m_tlast;

    // tracking copy of the extractor state
    logic [7:0]         wanted_type_q = '0;
    logic [PHASE_W-1:0] walk_phase    = PH_TYPE;
    logic [7:0]         walk_type     = '0;
    logic [LEN_W-1:0]   walk_len      = '0;
    logic [LEN_W-1:0]   walk_left     = '0;
    int                 walk_groups   = 0;

    tlv_result_t pending_results[$];
    logic [7:0]  frame_q[$];

    int errors         = 0;
    int bytes_sent     = 0;
    int frames_sent    = 0;
    int results_seen   = 0;
    int type_writes    = 0;
    int src_idle_pct   = 0;
    int dst_idle_pct   = 0;
    int hold_asked     = 0;
    int hold_given     = 0;
    int hold_left      = 0;

    tlv_item_extractor_unit u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),   // [7:0] data_byte
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),   // [7:0] value_byte
        .m_tuser     (m_tuser),   // [2:0] result_kind
        .m_tlast     (m_tlast)
    );

    initial begin
        forever begin
            #1 aclk = ~aclk;
        end
    end

    initial begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

    function automatic void reset_walk();
        walk_phase  = PH_TYPE;
        walk_type   = '0;
        walk_len    = '0;
        walk_groups = 0;
        walk_left   = '0;
    endfunction

    task automatic post_result(input logic [7:0] value, input logic [KIND_W-1:0] kind,
                               input logic eor);
        tlv_result_t r;
        r.value = value;
        r.kind  = kind;
        r.eor   = eor;
        pending_results.push_back(r);
    endtask

    task automatic post_status(input logic [KIND_W-1:0] kind, input logic lst);
        post_result(8'h00, kind, 1'b1);
        if (lst) begin
            reset_walk();
        end else begin
            walk_phase = PH_IGNORE;
        end
    endtask

    task automatic predict_extract(input logic [7:0] b, input logic lst);
        case (walk_phase)
            PH_TYPE: begin
                walk_type = b;
                if (lst) begin
                    post_status(K_ENDTYPE, 1'b1);
                end else begin
                    walk_len    = '0;
                    walk_groups = 0;
                    walk_phase  = PH_LEN;
                end
            end
            PH_LEN: begin
                if (walk_len[LEN_W-1:LEN_W-GROUP_W] != '0) begin
                    post_status(K_BADLEN, lst);
                end else begin
                    walk_len = {walk_len[LEN_W-GROUP_W-1:0], b[GROUP_W-1:0]};
                    walk_groups++;
                    if (b[7]) begin
                        if (lst || walk_groups >= LEN_BYTES_MAX) post_status(K_BADLEN, lst);
                    end else if (walk_len == '0) begin
                        if (lst) post_status(K_NOTFOUND, 1'b1);
                        else walk_phase = PH_TYPE;
                    end else if (lst) begin
                        post_status(K_CUT, 1'b1);
                    end else begin
                        walk_left  = walk_len;
                        walk_phase = (walk_type == wanted_type_q) ? PH_EMIT : PH_SKIP;
                    end
                end
            end
            PH_SKIP: begin
                walk_left--;
                if (walk_left == '0) begin
                    if (lst) post_status(K_NOTFOUND, 1'b1);
                    else walk_phase = PH_TYPE;
                end else if (lst) begin
                    post_status(K_CUT, 1'b1);
                end
            end
            PH_EMIT: begin
                walk_left--;
                if (walk_left == '0) begin
                    post_result(b, K_VALUE, 1'b1);
                    if (lst) reset_walk();
                    else walk_phase = PH_IGNORE;
                end else if (lst) begin
                    post_status(K_CUT, 1'b1);
                end else begin
                    post_result(b, K_VALUE, 1'b0);
                end
            end
            default: begin
                if (lst) reset_walk();
            end
        endcase
    endtask

    // hold the beat until s_tready is seen high between edges
    task automatic send_byte(input logic [7:0] b, input logic lst);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= lst;
        do @(negedge aclk); while (!s_tready);
        predict_extract(b, lst);
        bytes_sent++;
        @(posedge aclk);
    endtask

    task automatic send_frame(input int keep);
        int i;
        for (i = 0; i < keep; i++) begin
            send_byte(frame_q[i], i == keep - 1);
        end
        frame_q.delete();
        frames_sent++;
    endtask

    task automatic append_item(input logic [7:0] t, input int unsigned len,
                               input int unsigned pad);
        logic [7:0]  grp[$];
        int unsigned v;
        int          i;
        v = len;
        frame_q.push_back(t);
        do begin
            grp.push_front(8'(v & 32'h7F));
            v = v >> GROUP_W;
        end while (v != 0);
        repeat (pad) grp.push_front(8'h00);
        for (i = 0; i < grp.size(); i++) begin
            frame_q.push_back((i < grp.size() - 1) ? (grp[i] | 8'h80) : grp[i]);
        end
        repeat (len) frame_q.push_back(8'($urandom));
    endtask

    task automatic wait_results_done();
        int guard;
        guard = 0;
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0 && guard < DRAIN_LIMIT) begin
            @(posedge aclk);
            guard++;
        end
        if (pending_results.size() != 0) begin
            $error("%0d expected result beats never arrived", pending_results.size());
            errors++;
            pending_results.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_wanted_type(input logic [7:0] v);
        wait_results_done();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en     <= 1'b0;
        wanted_type_q  = v;
        type_writes++;
    endtask

    task automatic test_directed_cases();
        frame_q = '{8'hFF};
        send_frame(frame_q.size());
        frame_q = '{8'h00, 8'h01, 8'hAB};
        send_frame(frame_q.size());
        frame_q = '{8'h05, 8'h00};
        send_frame(frame_q.size());
        frame_q = '{8'h07, 8'h02, 8'h11, 8'h22};
        send_frame(frame_q.size());
        frame_q = '{8'h00, 8'h81};
        send_frame(frame_q.size());
        frame_q = '{8'h00, 8'h80, 8'h80, 8'h80, 8'h81, 8'h44};
        send_frame(frame_q.size());
        frame_q = '{8'h00, 8'h03, 8'h5A};
        send_frame(frame_q.size());
        frame_q = '{8'h00, 8'h80, 8'h02, 8'h01, 8'h02, 8'hEE};
        send_frame(frame_q.size());
        frame_q = '{8'h01, 8'hFF, 8'hFF, 8'hFF, 8'h7F, 8'h00};
        send_frame(frame_q.size());
        frame_q = '{8'h00, 8'h05};
        send_frame(frame_q.size());
        wait_results_done();
    endtask

    task automatic test_wanted_type_extremes();
        write_wanted_type(8'hFF);
        frame_q = '{8'hFE, 8'h01, 8'h10, 8'hFF, 8'h02, 8'hC3, 8'h3C};
        send_frame(frame_q.size());
        frame_q = '{8'h00, 8'h01, 8'h77, 8'hFF, 8'h00};
        send_frame(frame_q.size());
        write_wanted_type(8'h00);
        frame_q = '{8'hFF, 8'h01, 8'h10, 8'h00, 8'h01, 8'h81};
        send_frame(frame_q.size());
        wait_results_done();
    endtask

    // stall the receiver while a long matched value keeps the sender busy
    task automatic test_output_backpressure();
        write_wanted_type(8'h5A);
        hold_asked++;
        append_item(8'h5A, 120, 0);
        append_item(8'h01, 3, 0);
        send_frame(frame_q.size());
        wait_results_done();
    endtask

    task automatic test_random_buffers(input int n_beats);
        int          stop_at;
        int          keep;
        int          roll;
        int          len_roll;
        int unsigned len;
        int unsigned groups;
        int unsigned pad;
        logic [7:0]  t;
        logic [7:0]  v;
        stop_at = bytes_sent + n_beats;
        while (bytes_sent < stop_at) begin
            if ($urandom_range(99) < 6) begin
                case ($urandom_range(3))
                    0:       v = 8'h00;
                    1:       v = 8'hFF;
                    default: v = 8'($urandom);
                endcase
                write_wanted_type(v);
            end
            roll = $urandom_range(99);
            if (roll < 7) begin
                repeat ($urandom_range(1, 12)) frame_q.push_back(8'($urandom));
                send_frame(frame_q.size());
            end else begin
                repeat ($urandom_range(1, 4)) begin
                    t        = ($urandom_range(99) < 35) ? wanted_type_q : 8'($urandom);
                    len_roll = $urandom_range(99);
                    if (len_roll < 20) len = 0;
                    else if (len_roll < 96) len = $urandom_range(1, 8);
                    else len = $urandom_range(9, 200);
                    groups = (len < 128) ? 1 : 2;
                    pad    = ($urandom_range(99) < 10) ?
                             $urandom_range(1, LEN_BYTES_MAX - groups) : 0;
                    append_item(t, len, pad);
                end
                if (roll < 15) begin
                    frame_q.push_back(8'($urandom));
                    repeat (LEN_BYTES_MAX) frame_q.push_back(8'h80 | 8'($urandom));
                    repeat ($urandom_range(0, 4)) frame_q.push_back(8'($urandom));
                end
                keep = (roll >= 15 && roll < 30) ? $urandom_range(1, frame_q.size())
                                                 : frame_q.size();
                send_frame(keep);
            end
        end
        wait_results_done();
    endtask

    initial begin
        forever begin
            @(posedge aclk);
            if (hold_asked != hold_given) begin
                hold_given = hold_asked;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= dst_idle_pct);
            end
        end
    end

    always @(negedge aclk) begin : check_results
        tlv_result_t got;
        tlv_result_t exp_r;
        if (aresetn && m_tvalid && m_tready) begin
            got.value = m_tdata;
            got.kind  = m_tuser;
            got.eor   = m_tlast;
            results_seen++;
            if (pending_results.size() == 0) begin
                $error("unexpected result beat: value_byte %0h result_kind %0d end %0b",
                       got.value, got.kind, got.eor);
                errors++;
            end else begin
                exp_r = pending_results.pop_front();
                if (got.value !== exp_r.value) begin
                    $error("value_byte: expected %0h, got %0h", exp_r.value, got.value);
                    errors++;
                end
                if (got.kind !== exp_r.kind) begin
                    $error("result_kind: expected %0d, got %0d", exp_r.kind, got.kind);
                    errors++;
                end
                if (got.eor !== exp_r.eor) begin
                    $error("end_of_result: expected %0b, got %0b", exp_r.eor, got.eor);
                    errors++;
                end
            end
        end
    end

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        src_idle_pct = 29;
        dst_idle_pct = 83;
        test_directed_cases();
        test_wanted_type_extremes();
        test_output_backpressure();
        test_random_buffers(255);

        src_idle_pct = 83;
        dst_idle_pct = 29;
        test_random_buffers(255);

        src_idle_pct = 0;
        dst_idle_pct = 0;
        test_random_buffers(245);

        wait_results_done();
        $display("covered %0d buffers, %0d input beats, %0d result beats, %0d type writes",
                 frames_sent, bytes_sent, results_seen, type_writes);
        $display("ran three idle profiles and a %0d-cycle receiver hold-off", HOLD_CYCLES);
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
sv/tie_pkg.sv
sv/tie_in_stage.sv
sv/tie_parser.sv
sv/tie_out_stage.sv
sv/tlv_item_extractor_unit.sv
tb/tlv_item_extractor_unit_test.sv
